// ===== sv/cpu8_alu_flag_unit_assert.svh =====
// Assertion macros shared by the checker of the ALU flag unit.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef CPU8_ALU_FLAG_UNIT_ASSERT_SVH
`define CPU8_ALU_FLAG_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define CFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, written as an implication from a trigger.
`define CFU_ASSERT_IMP(label, trig, prop, msg) \
  `CFU_ASSERT(label, (trig) |-> (prop), msg)

`endif

// ===== sv/cfu_pkg.sv =====
// Types, operation codes and result helpers of the ALU flag unit.
// Depends on nothing; used by every module of the block.
`default_nettype none

package cfu_pkg;

  typedef enum logic [2:0] {
    OP_ADC  = 3'd0,
    OP_CMP  = 3'd1,
    OP_INC  = 3'd2,
    OP_DEC  = 3'd3,
    OP_LD   = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6,
    OP_WORD = 3'd7
  } cfu_op_e;

  // Divide steps done in each divider stage, and number of such stages.
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages        = 4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [7:0] op_y;
    logic       carry_in;
  } cfu_in_t;

  typedef struct packed {
    logic [7:0] res_lo;
    logic [7:0] res_hi;
    logic       flag_n;
    logic       flag_z;
    logic       flag_c;
    logic       write_c;
    logic       flag_v;
    logic       write_v;
    logic       flag_h;
    logic       write_h;
  } cfu_out_t;

  // Running state of the restoring divider.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] dvd;
    logic [7:0]  quo;
    logic [7:0]  dsr;
  } cfu_div_t;

  // Word carried down the pipeline.
  typedef struct packed {
    cfu_out_t res;
    logic     is_div;
    cfu_div_t div;
  } cfu_word_t;

  // Folds the divider result into the result word for divide operations.
  function automatic cfu_out_t cfu_finish(cfu_word_t w);
    cfu_out_t r;
    r = w.res;
    if (w.is_div) begin
      r.res_lo = w.div.quo;
      r.res_hi = w.div.rem;
      r.flag_n = w.div.quo[7];
      r.flag_z = (w.div.quo == 8'h00);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cfu_front.sv =====
// First pipeline stage: decodes the operation and computes every result but divide.
// Depends on cfu_pkg.
`default_nettype none

module cfu_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cfu_pkg::cfu_in_t  word_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output cfu_pkg::cfu_word_t     word_o
);
  import cfu_pkg::*;

  logic      valid_q;
  cfu_word_t word_q, word_d;

  always_comb begin
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [15:0] prod;
    logic [7:0]  a, b, y;
    a    = word_i.op_a;
    b    = word_i.op_b;
    y    = word_i.op_y;
    sum  = {1'b0, a} + {1'b0, b} + {8'h00, word_i.carry_in};
    diff = {1'b0, a} - {1'b0, b};
    prod = {8'h00, y} * {8'h00, a};

    word_d            = '0;
    word_d.div.dvd    = {y, a};
    word_d.div.dsr    = b;
    word_d.res.res_lo = a;

    case (cfu_op_e'(word_i.req_type))
      OP_ADC: begin
        word_d.res.res_lo  = sum[7:0];
        word_d.res.flag_c  = sum[8];
        word_d.res.write_c = 1'b1;
        word_d.res.flag_v  = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
        word_d.res.write_v = 1'b1;
        word_d.res.flag_h  = sum[4] ^ a[4] ^ b[4];
        word_d.res.write_h = 1'b1;
      end
      OP_CMP: begin
        word_d.res.res_lo  = diff[7:0];
        word_d.res.flag_c  = ~diff[8];
        word_d.res.write_c = 1'b1;
      end
      OP_INC:  word_d.res.res_lo = a + 8'd1;
      OP_DEC:  word_d.res.res_lo = a - 8'd1;
      OP_LD:   word_d.res.res_lo = a;
      OP_MUL: begin
        word_d.res.res_lo = prod[7:0];
        word_d.res.res_hi = prod[15:8];
      end
      OP_DIV: begin
        word_d.is_div      = 1'b1;
        word_d.res.flag_v  = (y >= b);
        word_d.res.write_v = 1'b1;
        word_d.res.flag_h  = (y[3:0] >= b[3:0]);
        word_d.res.write_h = 1'b1;
      end
      OP_WORD: word_d.res.res_lo = a;
      default: word_d.res.res_lo = a;
    endcase

    // Sign and zero follow the low byte unless the operation says otherwise.
    word_d.res.flag_n = word_d.res.res_lo[7];
    word_d.res.flag_z = (word_d.res.res_lo == 8'h00);
    case (cfu_op_e'(word_i.req_type))
      OP_CMP:  word_d.res.flag_z = (a == b);
      OP_MUL: begin
        word_d.res.flag_n = prod[15];
        word_d.res.flag_z = (prod[15:8] == 8'h00);
      end
      OP_WORD: begin
        word_d.res.flag_n = y[7];
        word_d.res.flag_z = ({y, a} == 16'h0000);
      end
      default: ;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ===== sv/cfu_div_stage.sv =====
// One divider stage: DivStepsPerStage restoring divide steps followed by a pipeline register.
// Depends on cfu_pkg.
`default_nettype none

module cfu_div_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire cfu_pkg::cfu_word_t  word_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output cfu_pkg::cfu_word_t       word_o
);
  import cfu_pkg::*;

  logic      valid_q;
  cfu_word_t word_q, word_d;

  // Each step shifts one dividend bit into the remainder and subtracts the
  // divisor when it fits. A zero divisor leaves all-ones quotient bits and
  // the low dividend byte as remainder, which is the wanted result.
  always_comb begin
    logic [8:0] trial;
    cfu_div_t   d;
    d = word_i.div;
    for (int unsigned i = 0; i < DivStepsPerStage; i++) begin
      trial = {d.rem, d.dvd[15]};
      d.dvd = {d.dvd[14:0], 1'b0};
      if (trial >= {1'b0, d.dsr}) begin
        trial = trial - {1'b0, d.dsr};
        d.quo = {d.quo[6:0], 1'b1};
      end else begin
        d.quo = {d.quo[6:0], 1'b0};
      end
      d.rem = trial[7:0];
    end
    word_d     = word_i;
    word_d.div = d;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ===== sv/cpu8_alu_flag_unit.sv =====
// A word passes the front register and four divider registers, each stage
// holding one word. Throughput: one word per cycle unless out_ready_i
// stalls the output; each divider stage does four restoring steps.
// Reset (rst_ni, asynchronous, active low) empties every stage; the unit
// keeps no other state.
`default_nettype none

module cpu8_alu_flag_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cfu_pkg::cfu_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cfu_pkg::cfu_out_t      out_word_o
);
  import cfu_pkg::*;

  // Stage 0 is the front end; stages 1 to DivStages are the divider.
  // Every stage has its own valid bit, and a stage takes a new word when it
  // is empty or when its word moves on in the same cycle, so bubbles close
  // up and a stalled output holds everything behind it without loss.
  logic      valid [DivStages+1];
  logic      ready [DivStages+1];
  cfu_word_t word  [DivStages+1];

  cfu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .word_i  (in_word_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .word_o  (word[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    cfu_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .word_i  (word[s]),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .word_o  (word[s+1])
    );
  end

  // The last divider register is the output register. Divide operations
  // take their bytes and sign and zero flags from the divider state here.
  assign ready[DivStages] = out_ready_i;
  assign out_valid_o      = valid[DivStages];
  assign out_word_o       = cfu_finish(word[DivStages]);

endmodule

`default_nettype wire

// ===== sv/cfu_checker.sv =====
// Port-level checker of the ALU flag unit, bound to the top level.
// Depends on cfu_pkg and cpu8_alu_flag_unit_assert.svh.
`default_nettype none

`include "cpu8_alu_flag_unit_assert.svh"

module cfu_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire cfu_pkg::cfu_out_t out_word_o
);
  import cfu_pkg::*;

  `CFU_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o, "result word dropped while stalled")
  `CFU_ASSERT_IMP(a_flag_enable, out_valid_o, (!out_word_o.flag_c || out_word_o.write_c) && (!out_word_o.flag_v || out_word_o.write_v) && (!out_word_o.flag_h || out_word_o.write_h), "flag set without its write enable")
  `CFU_ASSERT_IMP(a_vh_pair, out_valid_o, out_word_o.write_v == out_word_o.write_h, "overflow and half carry enables differ")
  `CFU_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o, "empty pipeline refuses input")

endmodule

bind cpu8_alu_flag_unit cfu_checker u_cfu_checker (.*);

`default_nettype wire
